@@ hw/rtl/b64_pkg.sv @@
`default_nettype none

package b64_pkg;

    localparam int unsigned BURST_DEPTH = 6;
    localparam int unsigned BURST_IW    = $clog2(BURST_DEPTH);

    localparam logic [6:0] LINE_COLS = 7'd76;
    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] LF_CHAR   = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_valid;
        logic       end_of_stream;
    } item_t;

    // results of one item, entry 0 goes out first
    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] data;
        logic [BURST_IW-1:0]         cnt;
        logic                        last;
    } burst_t;

    typedef struct packed {
        logic       found;
        logic [5:0] value;
    } sextet_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic sextet_t dec_char(input logic [7:0] c);
        sextet_t s;
        s.found = 1'b1;
        s.value = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.found = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/base64_stream_codec.sv @@
// an accepted transaction waits in the input register until the result buffer can take its results
// throughput: one input transaction per cycle while each yields at most one result and m_tready
//   holds; otherwise the next item waits until the single-byte output port has drained the
//   result buffer (up to six bytes per item)
// reset: aresetn low at a clock edge clears mode (encode), group and column and empties buffers
`default_nettype none

module base64_stream_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,   // decode_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // in_byte
    input  wire logic       s_tuser,     // byte_valid
    input  wire logic       s_tlast,     // end_of_stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,     // out_byte
    output logic            m_tlast      // last_of_stream
);

    logic           in_valid_reg;
    b64_pkg::item_t in_item_reg;
    logic           can_load;
    logic           load;
    b64_pkg::burst_t burst;

    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.in_byte       <= s_tdata;
            in_item_reg.byte_valid    <= s_tuser;
            in_item_reg.end_of_stream <= s_tlast;
        end
    end

    b64_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (load),
        .item      (in_item_reg),
        .burst     (burst)
    );

    b64_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/b64_engine.sv @@
`default_nettype none

module b64_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           step,
    input  wire b64_pkg::item_t item,
    output b64_pkg::burst_t     burst
);

    logic        mode_reg;
    logic [23:0] gb_reg;
    logic [1:0]  gc_reg;
    logic [6:0]  col_reg;

    logic [23:0] gb_next;
    logic [1:0]  gc_next;
    logic [6:0]  col_next;

    logic                         quad_en;
    logic [6:0]                   col_sum;
    logic [7:0]                   c2;
    logic [7:0]                   c3;
    b64_pkg::sextet_t             sx;
    logic [b64_pkg::BURST_IW-1:0] n;

    always_comb begin
        gb_next  = gb_reg;
        gc_next  = gc_reg;
        col_next = col_reg;
        burst    = '0;
        n        = '0;
        quad_en  = 1'b0;
        col_sum  = '0;
        c2       = '0;
        c3       = '0;
        sx       = b64_pkg::dec_char(item.in_byte);

        if (!mode_reg) begin
            if (item.byte_valid) begin
                case (gc_next)
                    2'd0:    gb_next = gb_next | {item.in_byte, 16'h0000};
                    2'd1:    gb_next = gb_next | {8'h00, item.in_byte, 8'h00};
                    default: gb_next = gb_next | {16'h0000, item.in_byte};
                endcase
                gc_next = gc_next + 2'd1;
            end
            // full group, or a partial one closed by end of stream
            quad_en = (gc_next == 2'd3) || (item.end_of_stream && gc_next != 2'd0);
            if (quad_en) begin
                c2 = (gc_next >= 2'd2) ? b64_pkg::enc_char(gb_next[11:6]) : b64_pkg::PAD_CHAR;
                c3 = (gc_next == 2'd3) ? b64_pkg::enc_char(gb_next[5:0])  : b64_pkg::PAD_CHAR;
                burst.data[n] = b64_pkg::enc_char(gb_next[23:18]);
                n = n + b64_pkg::BURST_IW'(1);
                burst.data[n] = b64_pkg::enc_char(gb_next[17:12]);
                n = n + b64_pkg::BURST_IW'(1);
                burst.data[n] = c2;
                n = n + b64_pkg::BURST_IW'(1);
                burst.data[n] = c3;
                n = n + b64_pkg::BURST_IW'(1);
                col_sum = col_next + 7'd4;
                if (col_sum >= b64_pkg::LINE_COLS) begin
                    burst.data[n] = b64_pkg::LF_CHAR;
                    n = n + b64_pkg::BURST_IW'(1);
                    col_next = '0;
                end else begin
                    col_next = col_sum;
                end
                gb_next = '0;
                gc_next = '0;
            end
        end else begin
            if (item.byte_valid && sx.found) begin
                gb_next = {gb_next[17:0], sx.value};
                gc_next = gc_next + 2'd1;
                if (gc_next == 2'd0) begin
                    burst.data[n] = gb_next[23:16];
                    n = n + b64_pkg::BURST_IW'(1);
                    burst.data[n] = gb_next[15:8];
                    n = n + b64_pkg::BURST_IW'(1);
                    burst.data[n] = gb_next[7:0];
                    n = n + b64_pkg::BURST_IW'(1);
                    gb_next = '0;
                end
            end
            // three-character tail gives two bytes, two characters give one
            if (item.end_of_stream) begin
                if (gc_next == 2'd3) begin
                    burst.data[n] = gb_next[17:10];
                    n = n + b64_pkg::BURST_IW'(1);
                    burst.data[n] = gb_next[9:2];
                    n = n + b64_pkg::BURST_IW'(1);
                end else if (gc_next == 2'd2) begin
                    burst.data[n] = gb_next[11:4];
                    n = n + b64_pkg::BURST_IW'(1);
                end
            end
        end

        if (item.end_of_stream) begin
            burst.data[n] = b64_pkg::LF_CHAR;
            n = n + b64_pkg::BURST_IW'(1);
            burst.last = 1'b1;
            gb_next  = '0;
            gc_next  = '0;
            col_next = '0;
        end
        burst.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            gb_reg   <= '0;
            gc_reg   <= '0;
            col_reg  <= '0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
            gb_reg   <= '0;
            gc_reg   <= '0;
            col_reg  <= '0;
        end else if (step) begin
            gb_reg  <= gb_next;
            gc_reg  <= gc_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/b64_burst.sv @@
`default_nettype none

module b64_burst (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire b64_pkg::burst_t burst,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,   // out_byte
    output logic                 m_tlast    // last_of_stream
);

    logic [b64_pkg::BURST_DEPTH-1:0][7:0] data_reg;
    logic [b64_pkg::BURST_IW-1:0]         cnt_reg;
    logic                                 last_reg;

    logic take;

    assign take     = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[0];
    assign m_tlast  = last_reg && (cnt_reg == b64_pkg::BURST_IW'(1));
    // free now, or the final entry leaves this cycle
    assign can_load = (cnt_reg == '0) || (take && cnt_reg == b64_pkg::BURST_IW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end else if (load) begin
            cnt_reg  <= burst.cnt;
            last_reg <= burst.last;
        end else if (take) begin
            cnt_reg <= cnt_reg - b64_pkg::BURST_IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= burst.data;
        end else if (take) begin
            for (int i = 0; i < b64_pkg::BURST_DEPTH - 1; i++) begin
                data_reg[i] <= data_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_base64_stream_codec.sv @@
`default_nettype none

module tb_base64_stream_codec;
    timeunit 1ns;
    timeprecision 1ps;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] CR_CHAR       = 8'h0D;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         LIMIT_CYCLES  = 200000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_stream;
    } codec_out_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    b64_pkg::item_t send_q[$];
    codec_out_t     predicted_q[$];
    b64_pkg::item_t drv_item;
    codec_out_t     want;

    // predictor state
    logic        mode_q   = 1'b0;
    logic [23:0] grp_bits = 24'd0;
    logic [1:0]  grp_cnt  = 2'd0;
    logic [6:0]  col_cnt  = 7'd0;

    int err_cnt;
    int in_cnt;
    int out_cnt;
    int real_cnt;
    int stream_cnt;
    int cycle_cnt;
    bit steady;

    base64_stream_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int sextet_of(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (B64_ALPHABET[k] == c) return k;
        end
        return -1;
    endfunction

    task automatic clear_group();
        grp_bits = 24'd0;
        grp_cnt  = 2'd0;
        col_cnt  = 7'd0;
    endtask

    task automatic put_out(input logic [7:0] b, input logic last);
        codec_out_t r;
        r.out_byte       = b;
        r.last_of_stream = last;
        predicted_q.push_back(r);
    endtask

    // four characters, '=' in place of the sextets past the held bytes
    task automatic emit_group(input int held);
        put_out(B64_ALPHABET[grp_bits[23:18]], 1'b0);
        put_out(B64_ALPHABET[grp_bits[17:12]], 1'b0);
        put_out(held >= 2 ? B64_ALPHABET[grp_bits[11:6]] : b64_pkg::PAD_CHAR, 1'b0);
        put_out(held >= 3 ? B64_ALPHABET[grp_bits[5:0]] : b64_pkg::PAD_CHAR, 1'b0);
        col_cnt = col_cnt + 7'd4;
        if (col_cnt >= b64_pkg::LINE_COLS) begin
            put_out(b64_pkg::LF_CHAR, 1'b0);
            col_cnt = 7'd0;
        end
        grp_bits = 24'd0;
        grp_cnt  = 2'd0;
    endtask

    task automatic predict_codec(input b64_pkg::item_t it);
        int v;
        if (!mode_q) begin
            if (it.byte_valid) begin
                grp_bits = grp_bits | ({16'd0, it.in_byte} << (16 - 8 * int'(grp_cnt)));
                grp_cnt  = grp_cnt + 2'd1;
                if (grp_cnt == 2'd3) emit_group(3);
            end
            if (it.end_of_stream && grp_cnt != 2'd0) emit_group(int'(grp_cnt));
        end else begin
            v = it.byte_valid ? sextet_of(it.in_byte) : -1;
            if (v >= 0) begin
                grp_bits = {grp_bits[17:0], 6'(v)};
                grp_cnt  = grp_cnt + 2'd1;
                if (grp_cnt == 2'd0) begin
                    put_out(grp_bits[23:16], 1'b0);
                    put_out(grp_bits[15:8], 1'b0);
                    put_out(grp_bits[7:0], 1'b0);
                    grp_bits = 24'd0;
                end
            end
            if (it.end_of_stream) begin
                if (grp_cnt == 2'd3) begin
                    put_out(grp_bits[17:10], 1'b0);
                    put_out(grp_bits[9:2], 1'b0);
                end else if (grp_cnt == 2'd2) begin
                    put_out(grp_bits[11:4], 1'b0);
                end
            end
        end
        if (it.end_of_stream) begin
            put_out(b64_pkg::LF_CHAR, 1'b1);
            clear_group();
        end
    endtask

    // driver: one transaction per handshake, random gaps unless steady
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_codec(b64_pkg::item_t'({s_tdata, s_tuser, s_tlast}));
                in_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_q.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
                    drv_item = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_item.in_byte;
                    s_tuser  <= drv_item.byte_valid;
                    s_tlast  <= drv_item.end_of_stream;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_cnt++;
                if (predicted_q.size() == 0) begin
                    $error("unexpected output transaction: out_byte 0x%02h last_of_stream %0b",
                           m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = predicted_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.out_byte, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last_of_stream) begin
                        $error("last_of_stream mismatch: expected %0b, actual %0b",
                               want.last_of_stream, m_tlast);
                        err_cnt++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, predicted_q.size());
            $display("tb_base64_stream_codec failed");
            $finish;
        end
    end

    task automatic add_item(input logic [7:0] b, input logic valid, input logic eos);
        b64_pkg::item_t it;
        it.in_byte       = b;
        it.byte_valid    = valid;
        it.end_of_stream = eos;
        send_q.push_back(it);
        if (valid || eos) real_cnt++;
        if (eos) stream_cnt++;
    endtask

    // mostly alphabet characters, some padding, line breaks and junk
    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(19))
            0:       return b64_pkg::PAD_CHAR;
            1:       return b64_pkg::LF_CHAR;
            2:       return CR_CHAR;
            3:       return 8'($urandom);
            default: return B64_ALPHABET[$urandom_range(63)];
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(7) == 0) return $urandom_range(13, 40);
        return $urandom_range(0, 12);
    endfunction

    task automatic queue_stream(input bit text, input int n_data, input bit close);
        bit closed;
        bit eos;
        closed = 1'b0;
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            eos = close && i == n_data - 1 && $urandom_range(1) == 1;
            add_item(text ? pick_text_char() : 8'($urandom), 1'b1, eos);
            closed = eos;
        end
        if (close && !closed) add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_idle();
        while (send_q.size() != 0 || s_tvalid || predicted_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_q = m;
        clear_group();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // encoding after reset: empty stream, ignored item, full group, short tails
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hA5, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h7F, 1'b1, 1'b1);
        add_item(8'h01, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1);
        add_item(8'hAA, 1'b1, 1'b0);
        add_item(8'h55, 1'b1, 1'b1);

        // decoding: skipped characters, full groups, 3- and 1-character tails
        write_mode(1'b1);
        add_item("A", 1'b1, 1'b0);
        add_item(b64_pkg::PAD_CHAR, 1'b1, 1'b0);
        add_item("/", 1'b1, 1'b0);
        add_item(b64_pkg::LF_CHAR, 1'b1, 1'b0);
        add_item("+", 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item("z", 1'b1, 1'b0);
        add_item("0", 1'b1, 1'b0);
        add_item("9", 1'b1, 1'b0);
        add_item("a", 1'b1, 1'b0);
        add_item("Z", 1'b1, 1'b1);
        add_item("Q", 1'b1, 1'b0);
        add_item("B", 1'b1, 1'b0);
        add_item("C", 1'b1, 1'b1);
        add_item("x", 1'b1, 1'b0);
        add_item("A", 1'b0, 1'b1);
        add_item("M", 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b1);

        // long encode run past the line width with no idling on either side
        write_mode(1'b0);
        steady = 1'b1;
        queue_stream(1'b0, $urandom_range(57, 64), 1'b1);
        wait_idle();
        steady = 1'b0;

        while (real_cnt < 105) queue_stream(1'b0, pick_len(), 1'b1);
        queue_stream(1'b0, $urandom_range(58, 66), 1'b1);
        // partial group left behind, dropped by the mode write
        queue_stream(1'b0, 2, 1'b0);

        write_mode(1'b1);
        while (real_cnt < 195) queue_stream(1'b1, pick_len(), 1'b1);
        queue_stream(1'b1, 3, 1'b0);

        // rewriting the same mode also clears the held characters
        write_mode(1'b1);
        while (real_cnt < 205) queue_stream(1'b1, pick_len(), 1'b1);

        write_mode(1'b0);
        while (real_cnt < 212) queue_stream(1'b0, pick_len(), 1'b1);

        wait_idle();
        $display("covered %0d input transactions in %0d streams, encode and decode modes",
                 in_cnt, stream_cnt);
        $display("checked %0d output transactions, %0d errors", out_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_base64_stream_codec passed");
        end else begin
            $display("tb_base64_stream_codec failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/b64_pkg.sv
hw/rtl/b64_engine.sv
hw/rtl/b64_burst.sv
hw/rtl/base64_stream_codec.sv
tb/sv/tb_base64_stream_codec.sv
